// ----- rtl/ird_pkg.sv -----
// Package for the IR pulse-distance decoder: shared types, timing register
// indexes, reset values, result codes and fixed decoder constants.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ird_pkg;

  // Fixed decoder properties.
  localparam int DATA_CAPACITY     = 32;
  localparam int TOLERANCE_PERCENT = 10;
  localparam int PULSE_ADJUST      = 50;
  localparam int PERCENT_SCALE     = 100;
  localparam int CFG_COUNT         = 8;
  localparam int APB_ADDR_W        = $clog2(CFG_COUNT) + 2;

  // Timing register indexes.
  localparam logic [2:0] CFG_HDR_MARK   = 3'd0;
  localparam logic [2:0] CFG_HDR_SPACE  = 3'd1;
  localparam logic [2:0] CFG_ONE_MARK   = 3'd2;
  localparam logic [2:0] CFG_ONE_SPACE  = 3'd3;
  localparam logic [2:0] CFG_ZERO_MARK  = 3'd4;
  localparam logic [2:0] CFG_ZERO_SPACE = 3'd5;
  localparam logic [2:0] CFG_FOOT_MARK  = 3'd6;
  localparam logic [2:0] CFG_FOOT_SPACE = 3'd7;

  typedef logic signed [15:0] dur_t;
  typedef dur_t [CFG_COUNT-1:0] cfg_bank_t;

  localparam cfg_bank_t CFG_RESET = '{
    7: -16'sd19984,
    6: 16'sd717,
    5: -16'sd460,
    4: 16'sd710,
    3: -16'sd1590,
    2: 16'sd710,
    1: -16'sd4499,
    0: 16'sd8967
  };

  // Result codes.
  localparam logic       KIND_DATA           = 1'b0;
  localparam logic       KIND_SUMMARY        = 1'b1;
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_HDR_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW     = 2'd2;

  localparam logic [5:0] CAPACITY_COUNT = 6'(DATA_CAPACITY);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_DATA,
    PH_PEND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [5:0] byte_count;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Up to two results produced by one pulse pair, in order.
  typedef struct packed {
    logic [1:0] count;
    result_t    slot0;
    result_t    slot1;
  } result_push_t;

endpackage

// ----- rtl/ird_pulse_if.sv -----
// Input channel of the IR decoder: one mark/space pulse pair per transaction.
// Depends on ird_pkg for the duration type.
`timescale 1ns / 1ps

interface ird_pulse_if import ird_pkg::*; ();
  logic valid;
  logic ready;
  dur_t first_duration;
  dur_t second_duration;
  logic capture_start;
  logic capture_end;

  modport source (
    output valid, first_duration, second_duration, capture_start, capture_end,
    input  ready
  );
  modport sink (
    input  valid, first_duration, second_duration, capture_start, capture_end,
    output ready
  );
endinterface

// ----- rtl/ird_result_if.sv -----
// Output channel of the IR decoder: one data byte or summary per transaction.
// Depends on ird_pkg by convention; payload widths are fixed.
`timescale 1ns / 1ps

interface ird_result_if import ird_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] data_byte;
  logic [5:0] byte_count;
  logic [1:0] status;
  logic       last;

  modport source (
    output valid, result_kind, data_byte, byte_count, status, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, data_byte, byte_count, status, last,
    output ready
  );
endinterface

// ----- rtl/ird_cfg_regs.sv -----
// APB-style timing register bank: eight signed 16-bit expected durations.
// Depends on ird_pkg for the register type and reset values.
`timescale 1ns / 1ps

module ird_cfg_regs import ird_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_bank_t             cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;
  dur_t       rd_val;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      cfg[reg_idx] <= dur_t'(pwdata[15:0]);
    end
  end

  // Read data is the register value, sign extended.
  assign rd_val = cfg[reg_idx];
  assign prdata = {{16{rd_val[15]}}, rd_val};

endmodule

// ----- rtl/ird_decoder.sv -----
// Pulse pair decoder: input register, capture state and the single-pass
// classification of one pair into at most two results.
// Depends on ird_pkg and ird_pulse_if.
`timescale 1ns / 1ps

module ird_decoder import ird_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  ird_pulse_if.sink     pulse_in,
  input  cfg_bank_t     cfg,
  input  logic          space_ok,
  output result_push_t  push
);

  // Tolerance test without division: |A - E| <= floor(E*T/100) holds exactly
  // when 100*|A - E| <= E*T, since the left side is an integer.
  function automatic logic pulse_match(input dur_t a, input dur_t e);
    logic signed [17:0] adj;
    logic signed [17:0] expd;
    logic signed [17:0] diff;
    logic [16:0]        mag;
    logic [23:0]        lhs;
    logic [23:0]        rhs;
    logic               sign_ok;
    if (a < 0) begin
      sign_ok = (e <= 0);
      adj     = 18'(PULSE_ADJUST) - 18'(a);
      expd    = -18'(e);
    end else begin
      sign_ok = (e >= 0);
      adj     = 18'(a) - 18'(PULSE_ADJUST);
      expd    = 18'(e);
    end
    diff = adj - expd;
    mag  = diff[17] ? 17'(-diff) : 17'(diff);
    lhs  = 24'(mag) * 24'(PERCENT_SCALE);
    rhs  = 24'(expd[16:0]) * 24'(TOLERANCE_PERCENT);
    return sign_ok && (lhs <= rhs);
  endfunction

  function automatic result_t data_result(input logic [7:0] b);
    result_t r;
    r.result_kind = KIND_DATA;
    r.data_byte   = b;
    r.byte_count  = 6'd0;
    r.status      = STATUS_OK;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic result_t summary_result(input logic [5:0] cnt, input logic [1:0] st);
    result_t r;
    r.result_kind = KIND_SUMMARY;
    r.data_byte   = 8'd0;
    r.byte_count  = cnt;
    r.status      = st;
    r.last        = 1'b1;
    return r;
  endfunction

  // Input register.
  logic in_valid;
  dur_t in_first;
  dur_t in_second;
  logic in_start;
  logic in_end;
  logic proc;

  assign proc           = in_valid && space_ok;
  assign pulse_in.ready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pulse_in.ready) begin
      in_valid <= pulse_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pulse_in.valid && pulse_in.ready) begin
      in_first  <= pulse_in.first_duration;
      in_second <= pulse_in.second_duration;
      in_start  <= pulse_in.capture_start;
      in_end    <= pulse_in.capture_end;
    end
  end

  // Pair classification against the four timing pairs.
  logic hdr_ok, one_ok, zero_ok, foot_ok;

  assign hdr_ok  = pulse_match(in_first, cfg[CFG_HDR_MARK])
                && pulse_match(in_second, cfg[CFG_HDR_SPACE]);
  assign one_ok  = pulse_match(in_first, cfg[CFG_ONE_MARK])
                && pulse_match(in_second, cfg[CFG_ONE_SPACE]);
  assign zero_ok = pulse_match(in_first, cfg[CFG_ZERO_MARK])
                && pulse_match(in_second, cfg[CFG_ZERO_SPACE]);
  assign foot_ok = pulse_match(in_first, cfg[CFG_FOOT_MARK])
                && pulse_match(in_second, cfg[CFG_FOOT_SPACE]);

  // Capture state.
  phase_t     phase, phase_next;
  logic [5:0] byte_index, byte_index_next;
  logic [3:0] bit_position, bit_position_next;
  logic [7:0] current_byte, current_byte_next;
  logic [1:0] res_count;
  result_t    res_slot [2];

  always_comb begin
    logic do_finish;
    logic [5:0] fin_count;
    phase_next        = phase;
    byte_index_next   = byte_index;
    bit_position_next = bit_position;
    current_byte_next = current_byte;
    res_count         = 2'd0;
    res_slot[0]       = data_result(8'd0);
    res_slot[1]       = data_result(8'd0);
    do_finish         = 1'b0;
    fin_count         = 6'd0;

    if (in_start) begin
      // A new capture restarts decoding from any phase.
      byte_index_next   = 6'd0;
      bit_position_next = 4'd0;
      current_byte_next = 8'd0;
      if (!hdr_ok) begin
        phase_next  = PH_DONE;
        res_slot[0] = summary_result(6'd0, STATUS_HDR_MISMATCH);
        res_count   = 2'd1;
      end else begin
        phase_next = PH_DATA;
        do_finish  = in_end;
      end
    end else if (phase == PH_PEND) begin
      // After an unknown pair only a repeated header lets decoding go on.
      if (!hdr_ok) begin
        do_finish = 1'b1;
      end else begin
        if (byte_index < CAPACITY_COUNT) begin
          res_slot[0]       = data_result(current_byte);
          res_count         = 2'd1;
          bit_position_next = 4'd8;
        end
        phase_next = PH_DATA;
        do_finish  = in_end;
      end
    end else if (phase == PH_DATA) begin
      // A closed byte moves the index on and opens an empty byte.
      if (bit_position >= 4'd8) begin
        if (byte_index < CAPACITY_COUNT) begin
          byte_index_next = byte_index + 6'd1;
        end
        bit_position_next = 4'd0;
        current_byte_next = 8'd0;
      end
      if (one_ok || zero_ok || foot_ok) begin
        if (byte_index_next >= CAPACITY_COUNT) begin
          phase_next  = PH_DONE;
          res_slot[0] = summary_result(CAPACITY_COUNT, STATUS_OVERFLOW);
          res_count   = 2'd1;
        end else begin
          if (!one_ok && !zero_ok) begin
            bit_position_next = 4'd8;
          end else begin
            if (one_ok) begin
              current_byte_next[bit_position_next[2:0]] = 1'b1;
            end
            bit_position_next = bit_position_next + 4'd1;
          end
          if (bit_position_next == 4'd8) begin
            res_slot[0] = data_result(current_byte_next);
            res_count   = 2'd1;
          end
          do_finish = in_end;
        end
      end else if (in_end) begin
        do_finish = 1'b1;
      end else begin
        phase_next = PH_PEND;
      end
    end

    // Ending a capture: flush an open partial byte, then the summary.
    if (do_finish) begin
      fin_count = byte_index_next + ((bit_position_next != 4'd0) ? 6'd1 : 6'd0);
      if (bit_position_next != 4'd0 && bit_position_next < 4'd8) begin
        res_slot[res_count[0]] = data_result(current_byte_next);
        res_count              = res_count + 2'd1;
      end
      res_slot[res_count[0]] = summary_result(fin_count, STATUS_OK);
      res_count              = res_count + 2'd1;
      phase_next             = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT;
      byte_index   <= 6'd0;
      bit_position <= 4'd0;
      current_byte <= 8'd0;
    end else if (proc) begin
      phase        <= phase_next;
      byte_index   <= byte_index_next;
      bit_position <= bit_position_next;
      current_byte <= current_byte_next;
    end
  end

  assign push.count = proc ? res_count : 2'd0;
  assign push.slot0 = res_slot[0];
  assign push.slot1 = res_slot[1];

endmodule

// ----- rtl/ird_result_fifo.sv -----
// Result queue: takes up to two results a cycle, delivers one a cycle while the output is ready.
// Depends on ird_pkg and ird_result_if.
`timescale 1ns / 1ps

module ird_result_fifo import ird_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  result_push_t  push,
  output logic          space_ok,
  ird_result_if.source  result_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_1;
  logic [CNT_W-1:0] fill, fill_next;
  logic             pop;
  result_t          head;

  assign wr_ptr_1 = ptr_inc(wr_ptr);
  assign pop      = result_out.valid && result_out.ready;
  assign space_ok = fill <= CNT_W'(DEPTH - 2);

  // Storage writes, one or two entries per cycle.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.slot0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.slot1;
    end
  end

  // Pointers and fill level.
  assign fill_next = fill + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr_1;
      end else if (push.count == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr_1);
      end
    end
  end

  // Head of the queue drives the output channel.
  assign head                   = mem[rd_ptr];
  assign result_out.valid       = fill != '0;
  assign result_out.result_kind = head.result_kind;
  assign result_out.data_byte   = head.data_byte;
  assign result_out.byte_count  = head.byte_count;
  assign result_out.status      = head.status;
  assign result_out.last        = head.last;

endmodule

// ----- rtl/ir_pulse_distance_decoder.sv -----
// Top level of the IR pulse-distance decoder: timing registers, pair decoder
// and result queue. Depends on ird_pkg, ird_pulse_if, ird_result_if,
// ird_cfg_regs, ird_decoder and ird_result_fifo.
//
//   channel     direction  handshake         payload
//   pulse_in    in         valid / ready     first/second_duration, capture_start/end
//   result_out  out        valid / ready     result_kind, data_byte, byte_count,
//                                            status, last
//   APB         in/out     psel/penable      8 x 16-bit timing registers at 4*i
//
// One pulse pair is taken every cycle while the result queue has room. An accepted
// pair sits in the input register, and its results (none, one or two) are written
// into the result queue when it is processed; the queue then presents the first.
// A pair waits in the input register while fewer than two queue entries are
// free, and the input stalls behind it; with a stalled output that happens
// once RESULT_DEPTH-1 results are waiting.
// Synchronous reset empties the queue and returns to waiting for a header.
`timescale 1ns / 1ps

module ir_pulse_distance_decoder import ird_pkg::*; #(
  parameter int RESULT_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  ird_pulse_if.sink             pulse_in,
  ird_result_if.source          result_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_bank_t    cfg;
  result_push_t push;
  logic         space_ok;

  ird_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ird_decoder u_dec (
    .clk      (clk),
    .rst      (rst),
    .pulse_in (pulse_in),
    .cfg      (cfg),
    .space_ok (space_ok),
    .push     (push)
  );

  ird_result_fifo #(
    .DEPTH (RESULT_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .space_ok   (space_ok),
    .result_out (result_out)
  );

  // A pair never yields more than two results.
  a_push_max: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd3)
    else $error("decoder produced more than two results");

  // Results are only produced when the queue has room for two.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> space_ok)
    else $error("results pushed into a full queue");

  // When two results come from one pair, the second is always the summary.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.slot0.result_kind == KIND_DATA
                              && push.slot1.result_kind == KIND_SUMMARY))
    else $error("two results from one pair in the wrong order");

  // The queue is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_out.valid)
    else $error("result valid after reset");

endmodule

// ----- verif/tb_ir_pulse_distance_decoder.sv -----
// Self-checking testbench for the IR pulse-distance decoder: directed pulse pairs,
// then random captures under several timing settings, checked against a predictor.
// Depends on ird_pkg, ird_pulse_if, ird_result_if and ir_pulse_distance_decoder.
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder;
  import ird_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 8;
  localparam int MAX_WAIT     = 17;
  localparam int QUIET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 150000;
  localparam int PHASE_ITEMS  = 6;

  // Which timing pair a pulse pair is tested against; the value selects the register pair.
  typedef enum int {
    PAIR_HEADER = 0,
    PAIR_ONE    = 1,
    PAIR_ZERO   = 2,
    PAIR_FOOTER = 3
  } pair_kind_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_RESULT,
    ROW_ONE_RESULT
  } row_check_t;

  typedef struct packed {
    dur_t       first_d;
    dur_t       second_d;
    logic       start;
    logic       closing;
    row_check_t check;
    result_t    typed_res;
  } stim_row_t;

  localparam result_t NO_RESULT        = '0;
  localparam result_t HDR_BAD_SUMMARY  = '{KIND_SUMMARY, 8'd0, 6'd0, STATUS_HDR_MISMATCH, 1'b1};
  localparam result_t HDR_ONLY_SUMMARY = '{KIND_SUMMARY, 8'd0, 6'd0, STATUS_OK, 1'b1};

  // Pulses that fit the reset timings, bar JUNK and DUR_*; HDR_EDGE_* sit on tolerance edges.
  localparam dur_t HDR_M      = 16'sd9017;
  localparam dur_t HDR_S      = -16'sd4449;
  localparam dur_t HDR_EDGE_M = 16'sd9913;
  localparam dur_t HDR_EDGE_S = -16'sd4000;
  localparam dur_t BIT_M      = 16'sd760;
  localparam dur_t ONE_S      = -16'sd1540;
  localparam dur_t ZERO_S     = -16'sd410;
  localparam dur_t FOOT_M     = 16'sd767;
  localparam dur_t FOOT_S     = -16'sd19934;
  localparam dur_t JUNK       = 16'sd0;
  localparam dur_t DUR_MAX    = 16'sh7fff;
  localparam dur_t DUR_MIN    = 16'sh8000;

  localparam stim_row_t DIRECTED_ROWS [27] = '{
    // Ignored while waiting, header mismatch at the extremes, ignored once done.
    '{DUR_MAX, DUR_MIN, 1'b0, 1'b0, ROW_NO_RESULT, NO_RESULT},
    '{DUR_MIN, DUR_MAX, 1'b1, 1'b0, ROW_ONE_RESULT, HDR_BAD_SUMMARY},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_NO_RESULT, NO_RESULT},
    // Header only, on the tolerance edges.
    '{HDR_EDGE_M, HDR_EDGE_S, 1'b1, 1'b1, ROW_ONE_RESULT, HDR_ONLY_SUMMARY},
    // A full byte, then a partial byte closed by a footer, then an empty byte.
    '{HDR_M, HDR_S, 1'b1, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ZERO_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ZERO_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ZERO_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ZERO_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{FOOT_M, FOOT_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{FOOT_M, FOOT_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    // Unknown pair, repeated header, then a partial byte at the end.
    '{JUNK, JUNK, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{HDR_M, HDR_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ZERO_S, 1'b0, 1'b1, ROW_PREDICT, NO_RESULT},
    // Restart in mid capture, then an unknown pair followed by another one.
    '{HDR_M, HDR_S, 1'b1, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{HDR_M, HDR_S, 1'b1, 1'b0, ROW_PREDICT, NO_RESULT},
    '{BIT_M, ONE_S, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{JUNK, JUNK, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    '{JUNK, DUR_MAX, 1'b0, 1'b0, ROW_PREDICT, NO_RESULT},
    // Unknown pair that also ends the capture.
    '{HDR_M, HDR_S, 1'b1, 1'b0, ROW_PREDICT, NO_RESULT},
    '{JUNK, JUNK, 1'b0, 1'b1, ROW_PREDICT, NO_RESULT}
  };

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ird_pulse_if  pulse_bus ();
  ird_result_if result_bus ();

  // Predictor state and its copy of the timing registers.
  dur_t       timing [CFG_COUNT];
  phase_t     dec_phase;
  int         byte_idx;
  int         bit_pos;
  logic [7:0] cur_byte;

  result_t awaited_results [$];
  int      error_count;
  int      result_count;
  int      cycle_count;
  bit      no_idle;

  ir_pulse_distance_decoder uut (
    .clk        (clk),
    .rst        (rst),
    .pulse_in   (pulse_bus),
    .result_out (result_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ir_pulse_distance_decoder regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(MAX_WAIT, 0));
  endfunction

  // A pulse matches when signs agree and the adjusted magnitude is within tolerance.
  function automatic bit pulse_fits(dur_t pulse, dur_t target);
    int a;
    int e;
    int d;
    a = pulse;
    e = target;
    if (a < 0) begin
      if (e > 0) return 1'b0;
      a = PULSE_ADJUST - a;
      e = -e;
    end else begin
      if (e < 0) return 1'b0;
      a = a - PULSE_ADJUST;
    end
    d = (e * TOLERANCE_PERCENT) / PERCENT_SCALE;
    return !(a < e - d || e + d < a);
  endfunction

  function automatic bit pair_fits(dur_t p0, dur_t p1, pair_kind_t kind);
    return pulse_fits(p0, timing[2 * kind]) && pulse_fits(p1, timing[2 * kind + 1]);
  endfunction

  function automatic result_t make_result(logic kind, logic [7:0] data, logic [5:0] count,
                                          logic [1:0] code);
    result_t r;
    r.result_kind = kind;
    r.data_byte   = data;
    r.byte_count  = count;
    r.status      = code;
    r.last        = kind;
    return r;
  endfunction

  // Ends a capture: an open partial byte goes out first, then the summary.
  task automatic finish_capture(ref result_t produced[$]);
    logic [5:0] count;
    count = 6'(byte_idx + ((bit_pos != 0) ? 1 : 0));
    if (bit_pos != 0 && bit_pos < 8)
      produced.push_back(make_result(KIND_DATA, cur_byte, 6'd0, STATUS_OK));
    dec_phase = PH_DONE;
    produced.push_back(make_result(KIND_SUMMARY, 8'd0, count, STATUS_OK));
  endtask

  // Works out the results that one accepted pulse pair causes.
  task automatic decode_pair(dur_t p0, dur_t p1, logic start, logic closing,
                             ref result_t produced[$]);
    bit is_one;
    bit is_zero;
    bit is_foot;
    if (start) begin
      byte_idx = 0;
      bit_pos  = 0;
      cur_byte = '0;
      if (!pair_fits(p0, p1, PAIR_HEADER)) begin
        dec_phase = PH_DONE;
        produced.push_back(make_result(KIND_SUMMARY, 8'd0, 6'd0, STATUS_HDR_MISMATCH));
      end else begin
        dec_phase = PH_DATA;
        if (closing) finish_capture(produced);
      end
      return;
    end

    // After an unknown pair only a repeated header keeps the capture going.
    if (dec_phase == PH_PEND) begin
      if (!pair_fits(p0, p1, PAIR_HEADER)) begin
        finish_capture(produced);
        return;
      end
      if (byte_idx < DATA_CAPACITY) begin
        produced.push_back(make_result(KIND_DATA, cur_byte, 6'd0, STATUS_OK));
        bit_pos = 8;
      end
      dec_phase = PH_DATA;
      if (closing) finish_capture(produced);
      return;
    end

    if (dec_phase != PH_DATA) return;

    if (bit_pos >= 8) begin
      if (byte_idx < DATA_CAPACITY) byte_idx++;
      bit_pos  = 0;
      cur_byte = '0;
    end

    is_one  = pair_fits(p0, p1, PAIR_ONE);
    is_zero = !is_one && pair_fits(p0, p1, PAIR_ZERO);
    is_foot = !is_one && !is_zero && pair_fits(p0, p1, PAIR_FOOTER);
    if (is_one || is_zero || is_foot) begin
      if (byte_idx >= DATA_CAPACITY) begin
        dec_phase = PH_DONE;
        produced.push_back(make_result(KIND_SUMMARY, 8'd0, CAPACITY_COUNT, STATUS_OVERFLOW));
        return;
      end
      if (is_foot) begin
        bit_pos = 8;
      end else begin
        if (is_one) cur_byte[bit_pos] = 1'b1;
        bit_pos++;
      end
      if (bit_pos == 8)
        produced.push_back(make_result(KIND_DATA, cur_byte, 6'd0, STATUS_OK));
      if (closing) finish_capture(produced);
      return;
    end

    if (closing) finish_capture(produced);
    else dec_phase = PH_PEND;
  endtask

  // Drives one pulse pair, waits for its transaction and records what it should cause.
  task automatic deliver(dur_t f, dur_t s, logic start, logic closing,
                         row_check_t check = ROW_PREDICT, result_t typed_res = NO_RESULT);
    result_t produced [$];
    int gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk);
      pulse_bus.valid = 1'b0;
    end
    @(negedge clk);
    pulse_bus.valid           = 1'b1;
    pulse_bus.first_duration  = f;
    pulse_bus.second_duration = s;
    pulse_bus.capture_start   = start;
    pulse_bus.capture_end     = closing;
    do @(posedge clk); while (!pulse_bus.ready);
    decode_pair(f, s, start, closing, produced);
    case (check)
      ROW_PREDICT:    foreach (produced[i]) awaited_results.push_back(produced[i]);
      ROW_ONE_RESULT: awaited_results.push_back(typed_res);
      default: ;
    endcase
  endtask

  // Picks a pulse inside the tolerance window of a target, where one exists.
  function automatic dur_t fitting_pulse(dur_t target);
    int e;
    int d;
    int lo;
    int hi;
    e = target;
    if (e >= 0) begin
      d  = (e * TOLERANCE_PERCENT) / PERCENT_SCALE;
      lo = e - d;
      hi = (e + d > 32767 - PULSE_ADJUST) ? 32767 - PULSE_ADJUST : e + d;
      if (lo > hi) return dur_t'($urandom);
      return dur_t'(int'($urandom_range(hi, lo)) + PULSE_ADJUST);
    end
    e  = -e;
    d  = (e * TOLERANCE_PERCENT) / PERCENT_SCALE;
    lo = (e - d < PULSE_ADJUST + 1) ? PULSE_ADJUST + 1 : e - d;
    hi = (e + d > 32768 + PULSE_ADJUST) ? 32768 + PULSE_ADJUST : e + d;
    if (lo > hi) return dur_t'($urandom);
    return dur_t'(PULSE_ADJUST - int'($urandom_range(hi, lo)));
  endfunction

  task automatic make_pair(pair_kind_t kind, output dur_t f, output dur_t s);
    f = fitting_pulse(timing[2 * kind]);
    s = fitting_pulse(timing[2 * kind + 1]);
  endtask

  // One capture: mostly a header first, then bits, footers and unknown pairs with random content.
  // With fill_bytes set, footers dominate so that the byte store runs full.
  task automatic run_capture(int pairs, bit fill_bytes);
    int   i;
    int   r;
    bit   reheader;
    bit   last_pair;
    dur_t f;
    dur_t s;
    reheader = 1'b0;
    if ($urandom_range(99, 0) < 90) make_pair(PAIR_HEADER, f, s);
    else begin
      f = dur_t'($urandom);
      s = dur_t'($urandom);
    end
    deliver(f, s, 1'b1, pairs == 0);
    for (i = 1; i <= pairs; i++) begin
      last_pair = (i == pairs) && (fill_bytes || $urandom_range(9, 0) != 0);
      r = $urandom_range(99, 0);
      if (reheader) begin
        make_pair(PAIR_HEADER, f, s);
        reheader = 1'b0;
      end else if (r < (fill_bytes ? 85 : 15)) make_pair(PAIR_FOOTER, f, s);
      else if (r < (fill_bytes ? 90 : 50)) make_pair(PAIR_ONE, f, s);
      else if (r < (fill_bytes ? 95 : 85)) make_pair(PAIR_ZERO, f, s);
      else begin
        f = dur_t'($urandom);
        s = dur_t'($urandom);
        reheader = ($urandom_range(2, 0) != 0);
      end
      deliver(f, s, 1'b0, last_pair);
    end
  endtask

  // Drops valid and holds off until every awaited result has arrived.
  task automatic wait_quiet();
    @(negedge clk);
    pulse_bus.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_timing(logic [2:0] idx, dur_t value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{16{value[15]}}, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    timing[idx] = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic load_timings(dur_t values [CFG_COUNT]);
    wait_quiet();
    for (int unsigned idx = 0; idx < CFG_COUNT; idx++) write_timing(3'(idx), values[idx]);
  endtask

  // A run of random captures with stray random pairs and the odd pause between them.
  task automatic run_captures(int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      n = $urandom_range(12, 0);
      run_capture(n, 1'b0);
      sent += n + 1;
      if ($urandom_range(3, 0) == 0) begin
        deliver(dur_t'($urandom), dur_t'($urandom), $urandom_range(7, 0) == 0,
                1'(($urandom_range(1, 0))));
        sent++;
      end
      if ($urandom_range(5, 0) == 0) wait_quiet();
    end
  endtask

  // Result side: random stalls, then each transaction is checked against the oldest expectation.
  initial begin
    result_t want;
    int      stall;
    result_bus.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        result_bus.ready = 1'b0;
      end
      @(negedge clk);
      result_bus.ready = 1'b1;
      do @(posedge clk); while (result_bus.valid !== 1'b1);
      result_count++;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing awaited (kind %0d)",
                                  result_count, result_bus.result_kind));
      end else begin
        want = awaited_results.pop_front();
        if (result_bus.result_kind !== want.result_kind)
          report_mismatch($sformatf("result %0d result_kind %0d, expected %0d", result_count,
                                    result_bus.result_kind, want.result_kind));
        if (result_bus.data_byte !== want.data_byte)
          report_mismatch($sformatf("result %0d data_byte %0h, expected %0h", result_count,
                                    result_bus.data_byte, want.data_byte));
        if (result_bus.byte_count !== want.byte_count)
          report_mismatch($sformatf("result %0d byte_count %0d, expected %0d", result_count,
                                    result_bus.byte_count, want.byte_count));
        if (result_bus.status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d", result_count,
                                    result_bus.status, want.status));
        if (result_bus.last !== want.last)
          report_mismatch($sformatf("result %0d last %0d, expected %0d", result_count,
                                    result_bus.last, want.last));
      end
    end
  end

  // Stimulus: reset, directed table, then random captures under several timing settings.
  initial begin
    dur_t setting [CFG_COUNT];
    rst                       = 1'b1;
    psel                      = 1'b0;
    penable                   = 1'b0;
    pwrite                    = 1'b0;
    paddr                     = '0;
    pwdata                    = '0;
    pulse_bus.valid           = 1'b0;
    pulse_bus.first_duration  = '0;
    pulse_bus.second_duration = '0;
    pulse_bus.capture_start   = 1'b0;
    pulse_bus.capture_end     = 1'b0;
    error_count               = 0;
    result_count              = 0;
    cycle_count               = 0;
    no_idle                   = 1'b0;
    for (int idx = 0; idx < CFG_COUNT; idx++) timing[idx] = CFG_RESET[idx];
    dec_phase = PH_WAIT;
    byte_idx  = 0;
    bit_pos   = 0;
    cur_byte  = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_ROWS[i])
      deliver(DIRECTED_ROWS[i].first_d, DIRECTED_ROWS[i].second_d, DIRECTED_ROWS[i].start,
              DIRECTED_ROWS[i].closing, DIRECTED_ROWS[i].check, DIRECTED_ROWS[i].typed_res);

    // Reset timings: fill the byte store until it overflows, then random captures.
    run_capture(44, 1'b1);
    run_captures(PHASE_ITEMS);

    // Plausible random timings, with no idling at either side.
    setting[CFG_HDR_MARK]   = dur_t'($urandom_range(20000, 3000));
    setting[CFG_HDR_SPACE]  = dur_t'(-int'($urandom_range(9000, 2000)));
    setting[CFG_ONE_MARK]   = dur_t'($urandom_range(1200, 300));
    setting[CFG_ONE_SPACE]  = dur_t'(-int'($urandom_range(2500, 1200)));
    setting[CFG_ZERO_MARK]  = ($urandom_range(1, 0) != 0) ? setting[CFG_ONE_MARK]
                                                          : dur_t'($urandom_range(1200, 300));
    setting[CFG_ZERO_SPACE] = dur_t'(-int'($urandom_range(800, 200)));
    setting[CFG_FOOT_MARK]  = dur_t'($urandom_range(1200, 300));
    setting[CFG_FOOT_SPACE] = dur_t'(-int'($urandom_range(30000, 8000)));
    load_timings(setting);
    no_idle = 1'b1;
    run_captures(PHASE_ITEMS);
    no_idle = 1'b0;

    // Extreme timings: widest marks and spaces, zero-length targets.
    setting[CFG_HDR_MARK]   = DUR_MAX;
    setting[CFG_HDR_SPACE]  = DUR_MIN;
    setting[CFG_ONE_MARK]   = 16'sd0;
    setting[CFG_ONE_SPACE]  = DUR_MIN;
    setting[CFG_ZERO_MARK]  = DUR_MAX;
    setting[CFG_ZERO_SPACE] = 16'sd0;
    setting[CFG_FOOT_MARK]  = DUR_MIN;
    setting[CFG_FOOT_SPACE] = DUR_MAX;
    load_timings(setting);
    run_captures(PHASE_ITEMS);

    // Opposite signs at the extremes.
    setting[CFG_HDR_MARK]   = DUR_MIN;
    setting[CFG_HDR_SPACE]  = DUR_MAX;
    setting[CFG_ONE_MARK]   = DUR_MAX;
    setting[CFG_ONE_SPACE]  = 16'sd0;
    setting[CFG_ZERO_MARK]  = DUR_MIN;
    setting[CFG_ZERO_SPACE] = DUR_MAX;
    setting[CFG_FOOT_MARK]  = 16'sd0;
    setting[CFG_FOOT_SPACE] = DUR_MIN;
    load_timings(setting);
    run_captures(PHASE_ITEMS);

    // Timings drawn from the whole 16-bit range.
    foreach (setting[idx]) setting[idx] = dur_t'($urandom);
    load_timings(setting);
    run_captures(PHASE_ITEMS);

    wait_quiet();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
    if (error_count == 0) begin
      $display("ir_pulse_distance_decoder regression: pass");
    end else begin
      $display("ir_pulse_distance_decoder regression: fail");
    end
    $finish;
  end

endmodule
